// ----- hdl/civ_command_frame_encoder_core_assert.svh -----
// assertion macros for the command frame encoder
`ifndef CIV_COMMAND_FRAME_ENCODER_CORE_ASSERT_SVH
`define CIV_COMMAND_FRAME_ENCODER_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define CIV_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("frame encoder check failed");

// next-cycle implication, checked outside reset
`define CIV_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("frame encoder sequencing check failed");

`endif

// ----- hdl/civ_enc_pkg.sv -----
// shared constants and types of the command frame encoder
package civ_enc_pkg;

    localparam int BCD_BYTES = 5;
    localparam int DIGITS    = 2 * BCD_BYTES;
    localparam int BCD_W     = 4 * DIGITS;
    localparam int FREQ_W    = 34;
    localparam int STAGES    = 5;
    localparam int BPS       = (FREQ_W + STAGES - 1) / STAGES;
    localparam int PAD_W     = STAGES * BPS;

    localparam int HDR_LEN   = 5;
    localparam int FRAME_MAX = HDR_LEN + BCD_BYTES + 1;
    localparam int IDX_W     = $clog2(FRAME_MAX);

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_RADIO = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CTRL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MODE  = 2'd2;

    localparam logic [7:0] RST_RADIO = 8'h00;
    localparam logic [7:0] RST_CTRL  = 8'hE0;
    localparam logic [7:0] RST_MODE  = 8'h01;

    localparam logic [7:0] PREAMBLE_BYTE = 8'hFE;
    localparam logic [7:0] END_BYTE      = 8'hFD;
    localparam logic [7:0] CMD_SET_FREQ  = 8'h05;
    localparam logic [7:0] CMD_SET_MODE  = 8'h06;

    localparam logic REQ_SET_MODE = 1'b0;
    localparam logic REQ_SET_FREQ = 1'b1;

    typedef logic [BCD_W-1:0]  t_bcd;
    typedef logic [FREQ_W-1:0] t_freq;

    typedef struct packed {
        logic kind;
        t_bcd bcd;
    } t_pipe_item;

endpackage

// ----- hdl/civ_enc_if.sv -----
// stream and configuration interfaces of the command frame encoder
interface civ_req_if
    import civ_enc_pkg::*;
;
    logic  valid;
    logic  ready;
    logic  req_type;
    t_freq frequency_hz;

    modport source (output valid, output req_type, output frequency_hz, input ready);
    modport sink   (input valid, input req_type, input frequency_hz, output ready);
endinterface

interface civ_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last_byte;

    modport source (output valid, output frame_byte, output last_byte, input ready);
    modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

interface civ_cfg_if
    import civ_enc_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [7:0]           data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hdl/civ_enc_bcd_pipe.sv -----
// pipelined binary to packed bcd conversion, BPS (7) bits per stage
module civ_enc_bcd_pipe
    import civ_enc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_kind,
    input  t_freq      i_freq,
    output logic       o_valid,
    input  logic       i_ready,
    output t_pipe_item o_item
);

    function automatic t_bcd dd_chunk(input t_bcd acc_in, input logic [BPS-1:0] chunk);
        t_bcd acc;
        acc = acc_in;
        for (int j = 0; j < BPS; j++) begin
            for (int d = 0; d < DIGITS; d++) begin
                if (acc[d*4 +: 4] >= 4'd5) begin
                    acc[d*4 +: 4] = acc[d*4 +: 4] + 4'd3;
                end
            end
            // top digit overflow drops out: only the low digits are kept
            acc = {acc[BCD_W-2:0], chunk[BPS-1-j]};
        end
        return acc;
    endfunction

    logic             r_vld  [STAGES];
    logic             r_kind [STAGES];
    t_bcd             r_acc  [STAGES];
    logic [PAD_W-1:0] r_bin  [STAGES];

    logic             adv    [STAGES+1];
    t_bcd             n_acc  [STAGES];
    logic [PAD_W-1:0] n_bin  [STAGES];

    always_comb begin
        adv[STAGES] = i_ready;
        for (int k = STAGES - 1; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    always_comb begin
        logic [PAD_W-1:0] src_bin;
        t_bcd             src_acc;
        for (int k = 0; k < STAGES; k++) begin
            if (k == 0) begin
                src_bin = PAD_W'(i_freq);
                src_acc = '0;
            end else begin
                src_bin = r_bin[k-1];
                src_acc = r_acc[k-1];
            end
            n_acc[k] = dd_chunk(src_acc, src_bin[PAD_W-1 -: BPS]);
            n_bin[k] = src_bin << BPS;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < STAGES; k++) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (adv[k]) begin
                r_vld[k] <= (k == 0) ? i_valid : r_vld[k-1];
            end
            if (adv[k]) begin
                r_kind[k] <= (k == 0) ? i_kind : r_kind[k-1];
                r_acc[k]  <= n_acc[k];
                r_bin[k]  <= n_bin[k];
            end
        end
    end

    assign o_ready     = adv[0];
    assign o_valid     = r_vld[STAGES-1];
    assign o_item.kind = r_kind[STAGES-1];
    assign o_item.bcd  = r_acc[STAGES-1];

endmodule

// ----- hdl/civ_command_frame_encoder_core.sv -----
// command frame encoder top: config registers, bcd pipeline, byte serializer
// a request passes the bcd pipeline stages, then the serializer, then the output register
// throughput: one byte per cycle while o_byte.ready is high; a set-frequency frame is 11 bytes,
// set-mode 7, sent by the single byte serializer behind the five-stage bcd pipeline
// reset (synchronous, active low) empties the pipeline and output register and
// restores radio 00, controller E0, mode 01
module civ_command_frame_encoder_core
    import civ_enc_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    civ_req_if.sink    i_req,
    civ_cfg_if.sink    i_cfg,
    civ_byte_if.source o_byte
);

`include "civ_command_frame_encoder_core_assert.svh"

    logic [7:0] r_radio, r_ctrl, r_mode;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radio <= RST_RADIO;
            r_ctrl  <= RST_CTRL;
            r_mode  <= RST_MODE;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_RADIO: r_radio <= i_cfg.data;
                REG_CTRL:  r_ctrl  <= i_cfg.data;
                REG_MODE:  r_mode  <= i_cfg.data;
                default:   ;
            endcase
        end
    end

    logic       pipe_valid;
    logic       load;
    t_pipe_item pipe_item;

    civ_enc_bcd_pipe u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .o_ready (i_req.ready),
        .i_kind  (i_req.req_type),
        .i_freq  (i_req.frequency_hz),
        .o_valid (pipe_valid),
        .i_ready (load),
        .o_item  (pipe_item)
    );

    logic             r_busy;
    logic             r_kind;
    logic [IDX_W-1:0] r_idx;
    t_bcd             r_bcd;
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_last;

    logic             gen;
    logic             gen_last;
    logic [IDX_W-1:0] last_idx;
    logic [7:0]       n_byte;

    assign last_idx = (r_kind == REQ_SET_FREQ) ? IDX_W'(HDR_LEN + BCD_BYTES)
                                               : IDX_W'(HDR_LEN + 1);
    assign gen      = r_busy && (!r_out_valid || o_byte.ready);
    assign gen_last = gen && (r_idx == last_idx);
    assign load     = !r_busy || gen_last;

    always_comb begin
        case (r_idx)
            IDX_W'(0), IDX_W'(1): n_byte = PREAMBLE_BYTE;
            IDX_W'(2):            n_byte = r_radio;
            IDX_W'(3):            n_byte = r_ctrl;
            IDX_W'(4):            n_byte = (r_kind == REQ_SET_FREQ) ? CMD_SET_FREQ
                                                                    : CMD_SET_MODE;
            default: begin
                if (r_idx == last_idx) begin
                    n_byte = END_BYTE;
                end else if (r_kind == REQ_SET_FREQ) begin
                    n_byte = r_bcd[7:0];
                end else begin
                    n_byte = r_mode;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (load) begin
            r_busy <= pipe_valid;
        end
        if (load) begin
            r_kind <= pipe_item.kind;
            r_bcd  <= pipe_item.bcd;
            r_idx  <= '0;
        end else if (gen) begin
            r_idx <= r_idx + IDX_W'(1);
            // data bytes leave lowest pair first
            if (r_idx >= IDX_W'(HDR_LEN)) begin
                r_bcd <= r_bcd >> 8;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (gen) begin
            r_out_valid <= 1'b1;
        end else if (o_byte.ready) begin
            r_out_valid <= 1'b0;
        end
        if (gen) begin
            r_out_byte <= n_byte;
            r_out_last <= gen_last;
        end
    end

    assign o_byte.valid      = r_out_valid;
    assign o_byte.frame_byte = r_out_byte;
    assign o_byte.last_byte  = r_out_last;

    `CIV_ASSERT_NOW(a_last_is_end, r_out_valid && r_out_last, r_out_byte == END_BYTE)
    `CIV_ASSERT_NOW(a_idx_bound, r_busy, r_idx <= last_idx)
    `CIV_ASSERT_NEXT(a_done_idle, gen_last && !pipe_valid, !r_busy)
    `CIV_ASSERT_NEXT(a_load_starts, load && pipe_valid, r_busy && (r_idx == '0))

endmodule
